// ----- sv/tccs_pkg.sv -----
// Package for the text console cursor/scroll core.
// Holds the transaction payload types, field widths and character and action codes.
package tccs_pkg;

   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int CELL_IDX_W = 11;
   localparam int CURSOR_W   = 11;
   localparam int CELL_W     = 16;
   localparam int ATTR_W     = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_ATTR = 1'b0;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [CHAR_W-1:0]     char_code;
      logic [CELL_IDX_W-1:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_position;
      logic [CELL_W-1:0]   cell_data;
      logic                scrolled;
   } rsp_type;

endpackage

// ----- sv/tccs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Standalone; no package dependencies.
module tccs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/text_console_cursor_scroll_core.sv -----
// Text console writer: screen store of ROWS x COLS cells, cursor tracking, scroll and clear.
// Depends on tccs_pkg and tccs_ram.
//
// One transaction at a time; busy is high while it runs and results cannot be stalled.
// The screen store has a single write port and a single read port; puts, scrolls, clears
// and reads go through it, and the unused action code answers without touching it. A put
// that first scrolls copies the rows up and blanks the last row before the put itself. A
// clear blanks the whole store. After reset a clearing pass blanks the store with attribute
// 15; start is not taken until it ends, while configuration writes are taken as ever.
module text_console_cursor_scroll_core #(
   parameter int COLS = 80,
   parameter int ROWS = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tccs_pkg::req_type                   req_payload,
   output logic                                rsp_strobe,
   output tccs_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [tccs_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [tccs_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [tccs_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   import tccs_pkg::*;

   localparam int SPAN  = ROWS * COLS;
   localparam int AW    = $clog2(SPAN);
   localparam int CUR_W = $clog2(SPAN + 1);
   localparam int COL_W = $clog2(COLS);
   localparam int IW    = (CUR_W > CELL_IDX_W) ? CUR_W : CELL_IDX_W;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_FILL   = 7'b0000010,
      ST_SCROLL = 7'b0000100,
      ST_DRAIN  = 7'b0001000,
      ST_PUT    = 7'b0010000,
      ST_READ   = 7'b0100000,
      ST_RDWAIT = 7'b1000000
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        cnt_ff, cnt_in;
   logic [CUR_W-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [CELL_W-1:0]    fill_ff, fill_in;
   logic                 fill_rsp_ff, fill_rsp_in;
   logic                 scrolled_ff, scrolled_in;
   req_type              req_ff, req_in;
   logic                 cp_we_ff, cp_we_in;
   logic [AW-1:0]        cp_addr_ff, cp_addr_in;
   logic                 cp_tail_ff, cp_tail_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff, rsp_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [CELL_W-1:0]    ram_wdata;
   logic [AW-1:0]        ram_raddr;
   logic [CELL_W-1:0]    ram_rdata;

   logic                 accept;
   logic                 csr_write;
   logic                 idx_ok;
   logic [AW:0]          src_addr;
   logic [CELL_W-1:0]    blank;

   tccs_ram #(
      .WIDTH (CELL_W),
      .DEPTH (SPAN)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ATTR) ? CSR_DATA_W'(attr_ff) : '0;
   assign blank      = {attr_ff, CH_SPACE};
   assign idx_ok     = IW'(req_ff.cell_index) < IW'(SPAN);
   assign src_addr   = (AW+1)'(cnt_ff) + (AW+1)'(COLS);

   // screen store port selection
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = cnt_ff;
      ram_wdata = fill_ff;
      ram_raddr = '0;
      unique case (state_ff)
         ST_FILL: begin
            ram_we = 1'b1;
         end
         ST_SCROLL, ST_DRAIN: begin
            ram_we    = cp_we_ff;
            ram_waddr = cp_addr_ff;
            ram_wdata = cp_tail_ff ? blank : ram_rdata;
            if (cnt_ff < AW'(SPAN - COLS)) begin
               ram_raddr = AW'(src_addr);
            end
         end
         ST_PUT: begin
            ram_we    = (req_ff.char_code != CH_CR) && (req_ff.char_code != CH_LF);
            ram_waddr = AW'(cursor_ff);
            ram_wdata = {attr_ff, req_ff.char_code};
         end
         ST_READ: begin
            if (idx_ok) begin
               ram_raddr = AW'(req_ff.cell_index);
            end
         end
         default: begin
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cursor_in     = cursor_ff;
      col_in        = col_ff;
      attr_in       = attr_ff;
      fill_in       = fill_ff;
      fill_rsp_in   = fill_rsp_ff;
      scrolled_in   = scrolled_ff;
      req_in        = req_ff;
      cp_we_in      = 1'b0;
      cp_addr_in    = cp_addr_ff;
      cp_tail_in    = cp_tail_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      if (csr_write && (csr_paddr[2] == CSR_IDX_ATTR)) begin
         attr_in = csr_pwdata[ATTR_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in      = req_payload;
               scrolled_in = 1'b0;
               cnt_in      = '0;
               case (req_payload.action)
                  ACT_PUT: begin
                     if (cursor_ff == CUR_W'(SPAN)) begin
                        scrolled_in = 1'b1;
                        cursor_in   = CUR_W'(SPAN - COLS);
                        col_in      = '0;
                        state_in    = ST_SCROLL;
                     end else begin
                        state_in = ST_PUT;
                     end
                  end
                  ACT_CLEAR: begin
                     cursor_in   = '0;
                     col_in      = '0;
                     fill_in     = blank;
                     fill_rsp_in = 1'b1;
                     state_in    = ST_FILL;
                  end
                  ACT_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_strobe_in          = 1'b1;
                     rsp_in.cursor_position = CURSOR_W'(cursor_ff);
                     rsp_in.cell_data       = '0;
                     rsp_in.scrolled        = 1'b0;
                  end
               endcase
            end
         end
         ST_FILL: begin
            cnt_in = cnt_ff + AW'(1);
            if (cnt_ff == AW'(SPAN - 1)) begin
               state_in = ST_IDLE;
               if (fill_rsp_ff) begin
                  rsp_strobe_in          = 1'b1;
                  rsp_in.cursor_position = CURSOR_W'(cursor_ff);
                  rsp_in.cell_data       = '0;
                  rsp_in.scrolled        = 1'b0;
               end
            end
         end
         ST_SCROLL: begin
            cp_we_in   = 1'b1;
            cp_addr_in = cnt_ff;
            cp_tail_in = cnt_ff >= AW'(SPAN - COLS);
            cnt_in     = cnt_ff + AW'(1);
            if (cnt_ff == AW'(SPAN - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUT;
         end
         ST_PUT: begin
            if (req_ff.char_code == CH_CR) begin
               cursor_in = cursor_ff - CUR_W'(col_ff);
            end else if (req_ff.char_code == CH_LF) begin
               cursor_in = cursor_ff + CUR_W'(COLS) - CUR_W'(col_ff);
            end else begin
               cursor_in = cursor_ff + CUR_W'(1);
            end
            if ((req_ff.char_code == CH_CR) || (req_ff.char_code == CH_LF) ||
                (col_ff == COL_W'(COLS - 1))) begin
               col_in = '0;
            end else begin
               col_in = col_ff + COL_W'(1);
            end
            rsp_strobe_in          = 1'b1;
            rsp_in.cursor_position = CURSOR_W'(cursor_in);
            rsp_in.cell_data       = '0;
            rsp_in.scrolled        = scrolled_ff;
            state_in               = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_RDWAIT;
         end
         ST_RDWAIT: begin
            rsp_strobe_in          = 1'b1;
            rsp_in.cursor_position = CURSOR_W'(cursor_ff);
            rsp_in.cell_data       = idx_ok ? ram_rdata : '0;
            rsp_in.scrolled        = 1'b0;
            state_in               = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_FILL;
         cnt_ff        <= '0;
         cursor_ff     <= '0;
         col_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         fill_ff       <= {ATTR_RESET, CH_SPACE};
         fill_rsp_ff   <= 1'b0;
         scrolled_ff   <= 1'b0;
         cp_we_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         cursor_ff     <= cursor_in;
         col_ff        <= col_in;
         attr_ff       <= attr_in;
         fill_ff       <= fill_in;
         fill_rsp_ff   <= fill_rsp_in;
         scrolled_ff   <= scrolled_in;
         cp_we_ff      <= cp_we_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      req_ff     <= req_in;
      cp_addr_ff <= cp_addr_in;
      cp_tail_ff <= cp_tail_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_strobe))
      else $error("neither busy nor a result after an accepted transaction");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while the sequencer is still running");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff <= CUR_W'(SPAN)) && (col_ff <= COL_W'(COLS - 1)))
      else $error("cursor or column out of range");

   a_end_col: assert property (@(posedge clock) disable iff (reset)
      (cursor_ff == CUR_W'(SPAN)) |-> (col_ff == '0))
      else $error("cursor at end of screen with non-zero column");

endmodule

// ----- verif/tb_text_console_cursor_scroll_core.sv -----
// Testbench for text_console_cursor_scroll_core: puts, clears and reads checked against
// a mirrored screen store and cursor kept in a small scoreboard class.
// Depends on tccs_pkg and the core; the attribute register is driven over the APB port.
module tb_text_console_cursor_scroll_core;
   import tccs_pkg::*;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int SPAN  = ROWS * COLS;
   localparam int REQ_W = $bits(req_type);
   localparam logic [ACTION_W-1:0]   ACT_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] ATTR_ADDR  = {CSR_IDX_ATTR, 2'b00};

   class console_mirror;
      logic [CELL_W-1:0] cells [SPAN];
      int unsigned       cursor;
      logic [ATTR_W-1:0] attribute;
      rsp_type           predicted_replies [$];
      int unsigned       failures;

      function new();
         attribute = ATTR_RESET;
         cursor    = 0;
         failures  = 0;
         for (int i = 0; i < SPAN; i++) cells[i] = {ATTR_RESET, CH_SPACE};
      endfunction

      function int unsigned pending();
         return predicted_replies.size();
      endfunction

      function void take_request(input req_type q);
         rsp_type           r;
         logic [CELL_W-1:0] blank;
         r     = '0;
         blank = {attribute, CH_SPACE};
         case (q.action)
            ACT_PUT: begin
               if (cursor >= SPAN) begin
                  for (int i = 0; i < SPAN - COLS; i++) cells[i] = cells[i + COLS];
                  for (int i = SPAN - COLS; i < SPAN; i++) cells[i] = blank;
                  cursor     = SPAN - COLS;
                  r.scrolled = 1'b1;
               end
               if (q.char_code == CH_CR) begin
                  cursor = cursor - cursor % COLS;
               end else if (q.char_code == CH_LF) begin
                  cursor = cursor + COLS - cursor % COLS;
               end else begin
                  cells[cursor] = {attribute, q.char_code};
                  cursor        = cursor + 1;
               end
            end
            ACT_CLEAR: begin
               cursor = 0;
               for (int i = 0; i < SPAN; i++) cells[i] = blank;
            end
            ACT_READ: begin
               if (q.cell_index < SPAN) r.cell_data = cells[q.cell_index];
            end
            default: begin
            end
         endcase
         r.cursor_position = CURSOR_W'(cursor);
         predicted_replies.push_back(r);
      endfunction

      function void check_reply(input rsp_type got);
         rsp_type want;
         if (predicted_replies.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            failures++;
            return;
         end
         want = predicted_replies.pop_front();
         if (got.cursor_position !== want.cursor_position) begin
            $display("%0t: cursor_position expected %0d actual %0d", $time,
                     want.cursor_position, got.cursor_position);
            failures++;
         end
         if (got.cell_data !== want.cell_data) begin
            $display("%0t: cell_data expected %h actual %h", $time,
                     want.cell_data, got.cell_data);
            failures++;
         end
         if (got.scrolled !== want.scrolled) begin
            $display("%0t: scrolled expected %b actual %b", $time,
                     want.scrolled, got.scrolled);
            failures++;
         end
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   start       = 1'b0;
   logic                   busy;
   req_type                req_payload = '0;
   logic                   rsp_strobe;
   rsp_type                rsp_payload;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   console_mirror mirror = new();
   logic          back_to_back = 1'b0;

   text_console_cursor_scroll_core #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) mirror.check_reply(rsp_payload);
         if (start && !busy) mirror.take_request(req_payload);
      end
   end

   function automatic int unsigned draw_gap();
      if ($urandom_range(0, 29) == 0) back_to_back = !back_to_back;
      return back_to_back ? 0 : $urandom_range(0, 15);
   endfunction

   function automatic req_type make_request(input logic [ACTION_W-1:0] action,
                                            input logic [CHAR_W-1:0] char_code,
                                            input logic [CELL_IDX_W-1:0] cell_index);
      req_type q;
      q.action     = action;
      q.char_code  = char_code;
      q.cell_index = cell_index;
      return q;
   endfunction

   // hold start high across back-to-back transactions
   task automatic send_item(input req_type item, input int unsigned gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
   endtask

   // step past the accepting edge so the last transaction is seen as in flight
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (mirror.pending() != 0 || busy) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic write_en, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write_en;
      csr_paddr   <= ATTR_ADDR;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic confirm_attribute(input logic [ATTR_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      if (rdata[ATTR_W-1:0] !== value) begin
         $display("%0t: text_attribute expected %h actual %h", $time, value,
                  rdata[ATTR_W-1:0]);
         mirror.failures++;
      end
   endtask

   task automatic program_attribute(input logic [ATTR_W-1:0] value);
      logic [CSR_DATA_W-1:0] rdata;
      csr_transfer(1'b1, {24'($urandom), value}, rdata);
      mirror.attribute = value;
      confirm_attribute(value);
   endtask

   // mostly text lines and line-feed runs so the cursor reaches the bottom and scrolls
   task automatic run_phase(input int unsigned items);
      int unsigned sent;
      int unsigned n;
      int unsigned kind;
      int unsigned reach;
      req_type     q;
      sent = 0;
      while (sent < items) begin
         kind = $urandom_range(0, 99);
         if (kind < 40)      n = $urandom_range(1, 24);
         else if (kind < 55) n = $urandom_range(3, 25);
         else if (kind < 85) n = $urandom_range(1, 4);
         else                n = 1;
         for (int k = 0; k < n; k++) begin
            q = REQ_W'($urandom);
            if (kind < 40) begin
               q.action = ACT_PUT;
               if (k == n - 1) q.char_code = $urandom_range(0, 1) ? CH_LF : CH_CR;
            end else if (kind < 55) begin
               q.action    = ACT_PUT;
               q.char_code = CH_LF;
            end else if (kind < 85) begin
               q.action = ACT_READ;
               if (mirror.cursor != 0 && $urandom_range(0, 3) != 0) begin
                  reach        = (mirror.cursor > 160) ? 160 : mirror.cursor;
                  q.cell_index = CELL_IDX_W'(mirror.cursor - 1 - $urandom_range(0, reach - 1));
               end
            end else if (kind >= 97) begin
               q.action = ACT_CLEAR;
            end
            send_item(q, draw_gap());
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      confirm_attribute(ATTR_RESET);

      send_item(make_request(ACT_READ, 8'h00, 11'd0), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd1999), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd2000), draw_gap());
      send_item(make_request(ACT_READ, 8'hFF, 11'd2047), draw_gap());
      send_item(make_request(ACT_UNUSED, 8'hFF, 11'd2047), draw_gap());
      send_item(make_request(ACT_PUT, 8'h00, 11'd0), draw_gap());
      send_item(make_request(ACT_PUT, 8'hFF, 11'd2047), draw_gap());
      send_item(make_request(ACT_PUT, 8'h41, 11'd0), draw_gap());
      send_item(make_request(ACT_PUT, CH_CR, 11'd0), draw_gap());
      send_item(make_request(ACT_PUT, 8'h42, 11'd0), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd0), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd1), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd2), draw_gap());
      send_item(make_request(ACT_PUT, CH_LF, 11'd0), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd80), draw_gap());
      send_item(make_request(ACT_CLEAR, 8'h00, 11'd0), draw_gap());
      send_item(make_request(ACT_READ, 8'h00, 11'd1), draw_gap());
      settle();

      program_attribute(8'h00);
      run_phase(125);
      settle();
      program_attribute(8'hFF);
      run_phase(125);
      settle();
      program_attribute(ATTR_W'($urandom_range(1, 254)));
      run_phase(125);
      settle();
      program_attribute(ATTR_RESET);
      run_phase(125);
      settle();
      repeat (40) @(posedge clock);

      if (mirror.failures == 0 && mirror.pending() == 0) begin
         $display("text_console_cursor_scroll_core regression: pass");
      end else begin
         $display("text_console_cursor_scroll_core regression: fail");
      end
      $finish;
   end

   initial begin
      #60_000_000;
      $display("text_console_cursor_scroll_core regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/tccs_pkg.sv
sv/tccs_ram.sv
sv/text_console_cursor_scroll_core.sv
verif/tb_text_console_cursor_scroll_core.sv
